FILE: sv/tcw_pkg.sv
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int COPY_COUNT = (ROWS - 1) * COLUMNS;

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int CNT_W  = $clog2(CELL_COUNT + 1);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int POS_W  = 11;

  // Character codes and attributes
  localparam logic [7:0]  RESET_ATTR    = 8'h07;
  localparam logic [7:0]  SPACE_CODE    = 8'h20;
  localparam logic [7:0]  CODE_CR       = 8'd13;
  localparam logic [7:0]  CODE_LF       = 8'd10;
  localparam logic [15:0] BLANK_DEFAULT = {RESET_ATTR, SPACE_CODE};

  // Request codes
  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Register indexes
  localparam logic REG_ATTR = 1'b0;

  // Queue depth between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_CHAR,
    OP_CR,
    OP_LF,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } op_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  char_code;
    logic [10:0] cell_address;
  } req_t;

  typedef struct packed {
    logic [POS_W-1:0] cursor_position;
    logic [15:0]      cell_data;
    logic             scrolled;
  } res_t;

  typedef struct packed {
    op_e               op;
    logic [7:0]        char_code;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

endpackage

FILE: sv/tcw_front.sv
module tcw_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  tcw_pkg::req_t       req_i,
  input  logic                queue_full_i,
  input  logic                init_busy_i,
  input  logic                attr_restore_i,
  output logic                push_o,
  output tcw_pkg::cmd_t       cmd_o,
  output logic [7:0]          attr_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import tcw_pkg::*;

  logic [7:0] attr_q;
  logic       cfg_wr;
  logic       reg_idx;

  // Stall while the queue is full or the store is being initialized
  assign busy   = queue_full_i | init_busy_i;
  assign push_o = start & ~busy;

  // Classify the request
  always_comb begin
    cmd_o.char_code = req_i.char_code;
    cmd_o.addr      = ADDR_W'(req_i.cell_address);
    unique case (req_i.req_type)
      REQ_PUT: begin
        if (req_i.char_code == CODE_CR) begin
          cmd_o.op = OP_CR;
        end else if (req_i.char_code == CODE_LF) begin
          cmd_o.op = OP_LF;
        end else begin
          cmd_o.op = OP_CHAR;
        end
      end
      REQ_CLEAR: cmd_o.op = OP_CLEAR;
      REQ_READ: begin
        // reads past the last cell return zero
        if (32'(req_i.cell_address) < CELL_COUNT) begin
          cmd_o.op = OP_READ;
        end else begin
          cmd_o.op = OP_NOP;
        end
      end
      default: cmd_o.op = OP_NOP;
    endcase
  end

  // Register port
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel & penable & pwrite & (reg_idx == REG_ATTR);
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == REG_ATTR) ? {24'd0, attr_q} : 32'd0;
  assign attr_o  = attr_q;

  // Hold the attribute; a clear restores the default
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= RESET_ATTR;
    end else if (attr_restore_i) begin
      attr_q <= RESET_ATTR;
    end else if (cfg_wr) begin
      attr_q <= pwdata[7:0];
    end
  end

endmodule

FILE: sv/tcw_queue.sv
module tcw_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tcw_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output tcw_pkg::cmd_t cmd_o,
  output logic          empty_o,
  output logic          full_o
);
  import tcw_pkg::*;

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign cmd_o   = slot_q[rd_ptr_q];

  // Advance pointers, wrapping at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

FILE: sv/tcw_back.sv
module tcw_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tcw_pkg::cmd_t cmd_i,
  input  logic          empty_i,
  input  logic [7:0]    attr_i,
  output logic          pop_o,
  output logic          init_busy_o,
  output logic          attr_restore_o,
  output logic          done_o,
  output tcw_pkg::res_t res_o
);
  import tcw_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ_WAIT,
    S_SCROLL,
    S_BLANK,
    S_CLEAR
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              pend_q, pend_d;
  logic [ADDR_W-1:0] wr_idx_q, wr_idx_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic              done_q, done_d;
  res_t              res_q, res_d;

  logic              emit;
  logic [15:0]       emit_data;
  logic              emit_scrolled;
  logic [COL_W:0]    col_inc;
  logic [ROW_W:0]    row_inc;
  logic              adv_row;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [15:0]       mem [CELL_COUNT];
  logic [15:0]       rdata_q;

  function automatic logic [ADDR_W-1:0] cell_index(logic [ROW_W-1:0] row,
                                                   logic [COL_W-1:0] col);
    cell_index = ADDR_W'(ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col));
  endfunction

  assign init_busy_o = (state_q == S_INIT);
  assign done_o      = done_q;
  assign res_o       = res_q;
  assign col_inc     = {1'b0, col_q} + 1'b1;
  assign row_inc     = {1'b0, row_q} + 1'b1;

  // Sequence the cell store and the cursor
  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    pend_d         = 1'b0;
    wr_idx_d       = wr_idx_q;
    row_d          = row_q;
    col_d          = col_q;
    pop_o          = 1'b0;
    attr_restore_o = 1'b0;
    emit           = 1'b0;
    emit_data      = 16'd0;
    emit_scrolled  = 1'b0;
    adv_row        = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = cnt_q[ADDR_W-1:0];
    mem_wdata      = BLANK_DEFAULT;
    mem_re         = 1'b0;
    mem_raddr      = cmd_i.addr;

    unique case (state_q)
      S_INIT, S_CLEAR: begin
        mem_we = 1'b1;
        if (32'(cnt_q) == CELL_COUNT - 1) begin
          emit    = (state_q == S_CLEAR);
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          unique case (cmd_i.op)
            OP_CHAR: begin
              mem_we    = 1'b1;
              mem_waddr = cell_index(row_q, col_q);
              mem_wdata = {attr_i, cmd_i.char_code};
              if (32'(col_inc) == COLUMNS) begin
                col_d   = '0;
                adv_row = 1'b1;
              end else begin
                col_d = COL_W'(col_inc);
                emit  = 1'b1;
              end
            end
            OP_CR: begin
              col_d = '0;
              emit  = 1'b1;
            end
            OP_LF: begin
              col_d   = '0;
              adv_row = 1'b1;
            end
            OP_CLEAR: begin
              attr_restore_o = 1'b1;
              row_d          = '0;
              col_d          = '0;
              cnt_d          = '0;
              state_d        = S_CLEAR;
            end
            OP_READ: begin
              mem_re  = 1'b1;
              state_d = S_READ_WAIT;
            end
            OP_NOP: emit = 1'b1;
            default: emit = 1'b1;
          endcase
          // Advance the row; passing the bottom starts a scroll
          if (adv_row) begin
            if (32'(row_inc) == ROWS) begin
              row_d   = ROW_W'(ROWS - 1);
              cnt_d   = '0;
              state_d = S_SCROLL;
            end else begin
              row_d = ROW_W'(row_inc);
              emit  = 1'b1;
            end
          end
        end
      end

      S_READ_WAIT: begin
        emit      = 1'b1;
        emit_data = rdata_q;
        state_d   = S_IDLE;
      end

      S_SCROLL: begin
        // Copy each cell one row up: read it ahead through the registered read port, then write it from rdata_q
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = wr_idx_q;
          mem_wdata = rdata_q;
        end
        if (32'(cnt_q) < COPY_COUNT) begin
          mem_re    = 1'b1;
          mem_raddr = ADDR_W'(cnt_q + CNT_W'(COLUMNS));
          pend_d    = 1'b1;
          wr_idx_d  = cnt_q[ADDR_W-1:0];
          cnt_d     = cnt_q + 1'b1;
        end else begin
          state_d = S_BLANK;
        end
      end

      S_BLANK: begin
        // Blank the last row in the current attribute
        mem_we    = 1'b1;
        mem_wdata = {attr_i, SPACE_CODE};
        if (32'(cnt_q) == CELL_COUNT - 1) begin
          emit          = 1'b1;
          emit_scrolled = 1'b1;
          state_d       = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      default: state_d = S_IDLE;
    endcase

    done_d                = emit;
    res_d.cursor_position = POS_W'(cell_index(row_d, col_d));
    res_d.cell_data       = emit_data;
    res_d.scrolled        = emit_scrolled;
  end

  // Hold state, cursor and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      cnt_q    <= '0;
      pend_q   <= 1'b0;
      wr_idx_q <= '0;
      row_q    <= '0;
      col_q    <= '0;
      done_q   <= 1'b0;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      pend_q   <= pend_d;
      wr_idx_q <= wr_idx_d;
      row_q    <= row_d;
      col_q    <= col_d;
      done_q   <= done_d;
      res_q    <= res_d;
    end
  end

  // Cell store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

endmodule

FILE: sv/text_console_writer_top.sv
// Text console writer: an 80x25 store of 16-bit cells (attribute high byte,
// character low byte) with a cursor. A request is taken when start is high
// and busy is low; each request gives exactly one result, shown on res_o for
// the single cycle in which done_o is high, and the receiver cannot stall it.
// A two-entry queue sits between the request side and the store sequencer,
// so requests are taken while earlier ones are still being carried out.
// Printable bytes, carriage return, line feed and out-of-range reads are
// carried out in the sequencer cycle in which they are popped, unless a wrap
// or line feed starts a scroll; a read also waits on the registered read port
// of the cell store. Each result is registered before it shows on res_o. A
// scroll walks the store through its single write port, and a clear rewrites
// every cell. After reset the store is filled with blanks, during which busy
// is high; register writes are taken throughout.
module text_console_writer_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  tcw_pkg::req_t req_i,
  output logic          done_o,
  output tcw_pkg::res_t res_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import tcw_pkg::*;

  logic       push;
  cmd_t       push_cmd;
  cmd_t       head_cmd;
  logic       queue_empty;
  logic       queue_full;
  logic       pop;
  logic       init_busy;
  logic       attr_restore;
  logic [7:0] attr;

  tcw_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .queue_full_i   (queue_full),
    .init_busy_i    (init_busy),
    .attr_restore_i (attr_restore),
    .push_o         (push),
    .cmd_o          (push_cmd),
    .attr_o         (attr),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  tcw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .empty_o (queue_empty),
    .full_o  (queue_full)
  );

  tcw_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (head_cmd),
    .empty_i        (queue_empty),
    .attr_i         (attr),
    .pop_o          (pop),
    .init_busy_o    (init_busy),
    .attr_restore_o (attr_restore),
    .done_o         (done_o),
    .res_o          (res_o)
  );

endmodule

FILE: tb/tb.sv
module tb;
  import tcw_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [2:0] ATTR_ADDR  = {REG_ATTR, 2'b00};
  localparam int         CYCLE_LIMIT = 15_000_000;
  localparam int         PHASE_ITEMS = 240;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        start   = 1'b0;
  logic        busy;
  req_t        req_i   = '0;
  logic        done_o;
  res_t        res_o;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predicted screen contents, cursor and attribute
  logic [15:0] screen_cells [CELL_COUNT];
  int unsigned cur_col;
  int unsigned cur_row;
  logic [7:0]  text_attr;

  req_t queued_requests [$];
  res_t awaited_reports [$];
  int   issue_count = 0;
  int   accept_count = 0;
  int   fail_count = 0;
  int   cycle_count = 0;
  int   gap_left = 0;
  int   burst_left = 1;

  text_console_writer_top uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .done_o  (done_o),
    .res_o   (res_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Apply one request to the predicted console and return its report
  function automatic res_t advance_screen(req_t rq);
    res_t        r;
    int unsigned at;
    int          i;
    r = '0;
    case (rq.req_type)
      REQ_PUT: begin
        if (rq.char_code == CODE_CR) begin
          cur_col = 0;
        end else if (rq.char_code == CODE_LF) begin
          cur_col = 0;
          cur_row++;
        end else begin
          at = cur_row * COLUMNS + cur_col;
          if (at < CELL_COUNT) screen_cells[at] = {text_attr, rq.char_code};
          cur_col++;
        end
        // wrap at the row end
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
        // scroll up one row when the cursor passes the bottom
        if (cur_row >= ROWS) begin
          for (i = 0; i < COPY_COUNT; i++) screen_cells[i] = screen_cells[i + COLUMNS];
          for (i = COPY_COUNT; i < CELL_COUNT; i++) screen_cells[i] = {text_attr, SPACE_CODE};
          cur_row = ROWS - 1;
          r.scrolled = 1'b1;
        end
      end
      REQ_CLEAR: begin
        text_attr = RESET_ATTR;
        for (i = 0; i < CELL_COUNT; i++) screen_cells[i] = BLANK_DEFAULT;
        cur_col = 0;
        cur_row = 0;
      end
      REQ_READ: begin
        if (rq.cell_address < CELL_COUNT) r.cell_data = screen_cells[rq.cell_address];
      end
      default: begin
      end
    endcase
    r.cursor_position = POS_W'(cur_row * COLUMNS + cur_col);
    return r;
  endfunction

  // Drive requests in bursts with random gaps
  always @(negedge clk_i) begin
    if (!rst_ni || (start && accept_count != issue_count)) begin
      // hold the current transaction until it is taken
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left--;
    end else if (queued_requests.size() > 0) begin
      req_i <= queued_requests.pop_front();
      start <= 1'b1;
      issue_count++;
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
    end else begin
      start <= 1'b0;
    end
  end

  // Check results, then record accepted requests
  always @(posedge clk_i) begin : watch_results
    res_t want;
    cycle_count++;
    if (rst_ni && done_o) begin
      if (awaited_reports.size() == 0) begin
        $error("result with nothing expected: %h", res_o);
        fail_count++;
      end else begin
        want = awaited_reports.pop_front();
        if (res_o.cursor_position !== want.cursor_position) begin
          $error("cursor_position expected %0d actual %0d",
                 want.cursor_position, res_o.cursor_position);
          fail_count++;
        end
        if (res_o.cell_data !== want.cell_data) begin
          $error("cell_data expected %h actual %h", want.cell_data, res_o.cell_data);
          fail_count++;
        end
        if (res_o.scrolled !== want.scrolled) begin
          $error("scrolled expected %0d actual %0d", want.scrolled, res_o.scrolled);
          fail_count++;
        end
      end
    end
    if (rst_ni && start && !busy) begin
      awaited_reports.push_back(advance_screen(req_i));
      accept_count++;
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("text_console_writer_top regression: fail");
    $finish;
  end

  task automatic queue_item(input logic [1:0] kind, input logic [7:0] code,
                            input logic [10:0] addr);
    req_t rq;
    rq.req_type = kind;
    rq.char_code = code;
    rq.cell_address = addr;
    queued_requests.push_back(rq);
  endtask

  task automatic queue_read(input logic [10:0] addr);
    queue_item(REQ_READ, 8'($urandom_range(0, 255)), addr);
  endtask

  task automatic queue_put(input logic [7:0] code);
    queue_item(REQ_PUT, code, 11'($urandom_range(0, 2047)));
  endtask

  // Write the attribute register, then read it back
  task automatic write_attr(input logic [7:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ATTR_ADDR;
    pwdata <= {24'b0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    text_attr = val;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[7:0] !== val) begin
      $error("text_attribute expected %h actual %h", val, prdata[7:0]);
      fail_count++;
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Wait until every request is taken and answered
  task automatic wait_drained;
    @(posedge clk_i);
    while (queued_requests.size() != 0 || accept_count != issue_count || start ||
           awaited_reports.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Fill one phase with text lines, line feed runs, reads, unused codes and rare clears
  task automatic queue_text_phase(input int n);
    int count;
    int roll;
    int len;
    int k;
    count = 0;
    while (count < n) begin
      roll = $urandom_range(0, 999);
      if (roll < 3) begin
        queue_item(REQ_CLEAR, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
        count++;
      end else if (roll < 20) begin
        queue_item(REQ_UNUSED, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
        count++;
      end else if (roll < 220) begin
        roll = $urandom_range(0, 9);
        if (roll < 4) queue_read(11'($urandom_range(COPY_COUNT - COLUMNS, CELL_COUNT - 1)));
        else if (roll < 8) queue_read(11'($urandom_range(0, CELL_COUNT - 1)));
        else queue_read(11'($urandom_range(0, 2047)));
        count++;
      end else if (roll < 280) begin
        len = $urandom_range(1, 8);
        for (k = 0; k < len; k++) queue_put(CODE_LF);
        count += len;
      end else begin
        roll = $urandom_range(0, 9);
        if (roll < 5) len = $urandom_range(0, 4);
        else if (roll < 8) len = $urandom_range(5, 20);
        else len = $urandom_range(70, 100);
        for (k = 0; k < len; k++) queue_put(8'($urandom_range(0, 255)));
        count += len;
        // end most lines with CR LF, LF or CR
        roll = $urandom_range(0, 9);
        if (roll < 6) begin
          queue_put(CODE_CR);
          queue_put(CODE_LF);
          count += 2;
        end else if (roll < 8) begin
          queue_put(CODE_LF);
          count++;
        end else if (roll < 9) begin
          queue_put(CODE_CR);
          count++;
        end
      end
    end
  endtask

  initial begin : stimulus
    logic [7:0] attr_plan [6];
    int         p;
    int         i;
    attr_plan[0] = 8'h00;
    attr_plan[1] = 8'($urandom_range(0, 255));
    attr_plan[2] = 8'h80;
    attr_plan[3] = 8'h01;
    attr_plan[4] = 8'hFF;
    attr_plan[5] = 8'($urandom_range(0, 255));

    // Reset state of the prediction
    for (i = 0; i < CELL_COUNT; i++) screen_cells[i] = BLANK_DEFAULT;
    cur_col = 0;
    cur_row = 0;
    text_attr = RESET_ATTR;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);

    // Directed: read extremes, put edge bytes, CR, LF, unused code, clear
    write_attr(8'hFF);
    queue_read(11'd0);
    queue_read(11'(CELL_COUNT - 1));
    queue_read(11'(CELL_COUNT));
    queue_read(11'h7FF);
    queue_put(8'h00);
    queue_put(8'hFF);
    queue_put(CODE_CR);
    queue_put(8'h41);
    queue_read(11'd0);
    queue_read(11'd1);
    queue_put(CODE_LF);
    queue_put(8'h7E);
    queue_item(REQ_UNUSED, 8'hFF, 11'h7FF);
    queue_read(11'(COLUMNS));
    queue_item(REQ_CLEAR, 8'h00, 11'h000);
    queue_put(8'h5A);
    queue_read(11'd0);
    queue_read(11'(COLUMNS));
    wait_drained();

    // Random text phases, each under its own attribute
    for (p = 0; p < 6; p++) begin
      write_attr(attr_plan[p]);
      queue_text_phase(PHASE_ITEMS);
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("text_console_writer_top regression: pass");
    end else begin
      $display("text_console_writer_top regression: fail");
    end
    $finish;
  end

endmodule
